>>> design/hexjac_pkg.sv
// ----------------------------------------------------------------------------
// hexjac_pkg
// Shared types, codes and index tables for the hex8 Jacobian inverse and
// deformation gradient block.
// ----------------------------------------------------------------------------
package hexjac_pkg;

    localparam int COORD_WIDTH_DEF = 32;
    localparam int FRAC_BITS_DEF   = 16;

    localparam logic       CMD_REF   = 1'b0;
    localparam logic       CMD_CUR   = 1'b1;
    localparam logic [2:0] NODE_FIRST = 3'd0;
    localparam logic [2:0] NODE_LAST  = 3'd7;
    localparam logic [3:0] IDX_LAST   = 4'd8;
    localparam logic [1:0] ROW_LAST   = 2'd2;
    localparam logic [1:0] TERM_COF_LAST = 2'd1;
    localparam logic [1:0] TERM_MAT_LAST = 2'd2;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_MAC_A,
        ST_MAC_B,
        ST_MAC_W,
        ST_CHECK,
        ST_DIV_GO,
        ST_DIV_W,
        ST_EMIT
    } ctrl_state_t;

    typedef enum logic [1:0] {
        PH_COF,
        PH_DET,
        PH_FMUL
    } phase_t;

    typedef struct packed {
        logic       start;
        logic       ld_a;
        logic       a_cof;
        logic       clr_acc;
        logic       ld_b;
        logic       b_inv;
        logic       sub;
        logic [3:0] idx;
        logic       cof_wr;
        logic       det_wr;
        logic       det_out_wr;
        logic       div_start;
        logic       inv_wr;
        logic       set_valid;
        logic       ref_fail;
        logic       miss;
        logic       fres_wr;
        logic       sums_clr;
        logic       shift_rows;
    } dp_cmd_t;

    typedef struct packed {
        logic mac_busy;
        logic div_busy;
        logic det_zero;
        logic ref_valid;
    } dp_stat_t;

    // cofactor k = s[a0]*s[b0] - s[a1]*s[b1]
    function automatic logic [3:0] cof_src_a(input logic [3:0] k, input logic second);
        logic [3:0] r;
        r = '0;
        case (k)
            4'd0: r = second ? 4'd5 : 4'd4;
            4'd1: r = second ? 4'd1 : 4'd2;
            4'd2: r = second ? 4'd2 : 4'd1;
            4'd3: r = second ? 4'd3 : 4'd5;
            4'd4: r = second ? 4'd2 : 4'd0;
            4'd5: r = second ? 4'd0 : 4'd2;
            4'd6: r = second ? 4'd4 : 4'd3;
            4'd7: r = second ? 4'd0 : 4'd1;
            4'd8: r = second ? 4'd1 : 4'd0;
            default: r = '0;
        endcase
        return r;
    endfunction

    function automatic logic [3:0] cof_src_b(input logic [3:0] k, input logic second);
        logic [3:0] r;
        r = '0;
        case (k)
            4'd0: r = second ? 4'd7 : 4'd8;
            4'd1: r = second ? 4'd8 : 4'd7;
            4'd2: r = second ? 4'd4 : 4'd5;
            4'd3: r = second ? 4'd8 : 4'd6;
            4'd4: r = second ? 4'd6 : 4'd8;
            4'd5: r = second ? 4'd5 : 4'd3;
            4'd6: r = second ? 4'd6 : 4'd7;
            4'd7: r = second ? 4'd7 : 4'd6;
            4'd8: r = second ? 4'd3 : 4'd4;
            default: r = '0;
        endcase
        return r;
    endfunction

    function automatic logic [1:0] row_of(input logic [3:0] e);
        logic [1:0] r;
        r = '0;
        case (e)
            4'd0, 4'd1, 4'd2: r = 2'd0;
            4'd3, 4'd4, 4'd5: r = 2'd1;
            4'd6, 4'd7, 4'd8: r = 2'd2;
            default: r = '0;
        endcase
        return r;
    endfunction

    function automatic logic [1:0] col_of(input logic [3:0] e);
        logic [1:0] r;
        r = '0;
        case (e)
            4'd0, 4'd3, 4'd6: r = 2'd0;
            4'd1, 4'd4, 4'd7: r = 2'd1;
            4'd2, 4'd5, 4'd8: r = 2'd2;
            default: r = '0;
        endcase
        return r;
    endfunction

endpackage

>>> design/hexjac_dp.sv
// ----------------------------------------------------------------------------
// hexjac_dp
// Datapath: Jacobian sums, bit-serial multiply-accumulate, restoring divider,
// stored inverse and the result rows.
// ----------------------------------------------------------------------------
module hexjac_dp #(
    parameter int COORD_WIDTH = hexjac_pkg::COORD_WIDTH_DEF,
    parameter int FRAC_BITS   = hexjac_pkg::FRAC_BITS_DEF
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          in_fire,
    input  logic                          command,
    input  logic [2:0]                    node_index,
    input  logic signed [COORD_WIDTH-1:0] coord_x,
    input  logic signed [COORD_WIDTH-1:0] coord_y,
    input  logic signed [COORD_WIDTH-1:0] coord_z,
    input  hexjac_pkg::dp_cmd_t           cmd,
    output hexjac_pkg::dp_stat_t          stat,
    output logic                          result_kind,
    output logic signed [31:0]            col0_value,
    output logic signed [31:0]            col1_value,
    output logic signed [31:0]            col2_value,
    output logic signed [63:0]            determinant,
    output logic                          singular
);
    import hexjac_pkg::*;

    localparam int SW  = COORD_WIDTH + 4;
    localparam int CFW = 2 * SW + 1;
    localparam int DW  = 3 * SW + 3;
    localparam int WW  = DW;
    localparam int MBW = (SW > 32) ? SW : 32;
    localparam int MCW = $clog2(MBW);
    localparam int NSH = 2 * FRAC_BITS + 3;
    localparam int NW  = CFW + NSH;
    localparam int DCW = $clog2(NW);
    localparam int DSH = 2 * FRAC_BITS + 9;
    localparam int FSH = FRAC_BITS + 3;
    localparam int XW  = DW + 64;

    logic signed [SW-1:0]  sums_reg [9];
    logic signed [SW-1:0]  sums_next [9];
    logic signed [CFW-1:0] cof_reg [9];
    logic signed [31:0]    inv_reg [9];
    logic signed [31:0]    res_reg [9];
    logic                  ref_valid_reg;
    logic signed [DW-1:0]  det_reg;
    logic signed [63:0]    det_out_reg;
    logic                  sing_reg;
    logic                  kind_reg;

    // multiply-accumulate unit
    logic [WW-1:0]  mcand_reg;
    logic [MBW-1:0] mplier_reg;
    logic [MCW-1:0] mcnt_reg;
    logic           mbusy_reg;
    logic           msub_reg;
    logic [WW-1:0]  acc_reg;

    // divider
    logic [NW-1:0] nmag_reg;
    logic [DW-1:0] dmag_reg;
    logic [DW-1:0] rem_reg;
    logic [32:0]   q_reg;
    logic          qovf_reg;
    logic          qneg_reg;
    logic [DCW-1:0] dcnt_reg;
    logic          dbusy_reg;

    logic signed [SW-1:0] xyz [3];
    logic [2:0]           pos;

    assign xyz[0] = SW'(coord_x);
    assign xyz[1] = SW'(coord_y);
    assign xyz[2] = SW'(coord_z);
    assign pos[0] = node_index[1] ^ node_index[0];
    assign pos[1] = node_index[1];
    assign pos[2] = node_index[2];

    always_comb
    begin
        for (int k = 0; k < 3; k++)
        begin
            for (int c = 0; c < 3; c++)
            begin
                sums_next[k*3+c] = ((node_index == NODE_FIRST) ? SW'(0) : sums_reg[k*3+c])
                                   + (pos[k] ? xyz[c] : -xyz[c]);
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < 9; i++)
            begin
                sums_reg[i] <= '0;
            end
        end
        else if (cmd.sums_clr)
        begin
            for (int i = 0; i < 9; i++)
            begin
                sums_reg[i] <= '0;
            end
        end
        else if (in_fire)
        begin
            sums_reg <= sums_next;
        end
    end

    // multiplier operands
    logic signed [WW-1:0]  a_ext;
    logic signed [MBW-1:0] b_ext;
    logic                  mneg;
    logic [WW-1:0]         addend;

    assign a_ext  = cmd.a_cof ? WW'(cof_reg[cmd.idx]) : WW'(sums_reg[cmd.idx]);
    assign b_ext  = cmd.b_inv ? MBW'(inv_reg[cmd.idx]) : MBW'(sums_reg[cmd.idx]);
    // top multiplier bit carries negative weight
    assign mneg   = msub_reg ^ (mcnt_reg == MCW'(MBW - 1));
    assign addend = mneg ? ~mcand_reg : mcand_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mbusy_reg <= 1'b0;
        end
        else if (cmd.ld_b)
        begin
            mbusy_reg <= 1'b1;
        end
        else if (mbusy_reg && mcnt_reg == MCW'(MBW - 1))
        begin
            mbusy_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.ld_a)
        begin
            mcand_reg <= a_ext;
            if (cmd.clr_acc)
            begin
                acc_reg <= '0;
            end
        end
        else if (mbusy_reg)
        begin
            if (mplier_reg[0])
            begin
                acc_reg <= acc_reg + addend + WW'(mneg);
            end
            mcand_reg <= mcand_reg << 1;
        end
        if (cmd.ld_b)
        begin
            mplier_reg <= b_ext;
            mcnt_reg   <= '0;
            msub_reg   <= cmd.sub;
        end
        else if (mbusy_reg)
        begin
            mplier_reg <= mplier_reg >> 1;
            mcnt_reg   <= mcnt_reg + MCW'(1);
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.cof_wr)
        begin
            cof_reg[cmd.idx] <= acc_reg[CFW-1:0];
        end
        if (cmd.det_wr)
        begin
            det_reg <= acc_reg;
        end
    end

    // divider: |cof| << NSH over |det|, one quotient bit a cycle
    logic signed [CFW-1:0] cof_sel;
    logic [CFW-1:0]        cmag;
    logic [DW-1:0]         dmag;
    logic [DW:0]           rem_sh;
    logic [DW:0]           rem_diff;
    logic                  qge;

    assign cof_sel  = cof_reg[cmd.idx];
    assign cmag     = cof_sel[CFW-1] ? CFW'(-cof_sel) : CFW'(cof_sel);
    assign dmag     = det_reg[DW-1] ? DW'(-det_reg) : DW'(det_reg);
    assign rem_sh   = {rem_reg, nmag_reg[NW-1]};
    assign rem_diff = rem_sh - {1'b0, dmag_reg};
    assign qge      = rem_sh >= {1'b0, dmag_reg};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            dbusy_reg <= 1'b0;
        end
        else if (cmd.div_start)
        begin
            dbusy_reg <= 1'b1;
        end
        else if (dbusy_reg && dcnt_reg == DCW'(NW - 1))
        begin
            dbusy_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.div_start)
        begin
            nmag_reg <= {cmag, {NSH{1'b0}}};
            dmag_reg <= dmag;
            rem_reg  <= '0;
            q_reg    <= '0;
            qovf_reg <= 1'b0;
            qneg_reg <= cof_sel[CFW-1] ^ det_reg[DW-1];
            dcnt_reg <= '0;
        end
        else if (dbusy_reg)
        begin
            nmag_reg <= nmag_reg << 1;
            rem_reg  <= qge ? rem_diff[DW-1:0] : rem_sh[DW-1:0];
            qovf_reg <= qovf_reg | q_reg[32];
            q_reg    <= {q_reg[31:0], qge};
            dcnt_reg <= dcnt_reg + DCW'(1);
        end
    end

    logic signed [31:0] qsat;

    always_comb
    begin
        if (qneg_reg)
        begin
            if (qovf_reg || q_reg > 33'h0_8000_0000)
            begin
                qsat = 32'sh8000_0000;
            end
            else
            begin
                qsat = -q_reg[31:0];
            end
        end
        else
        begin
            if (qovf_reg || q_reg[32] || q_reg[31])
            begin
                qsat = 32'sh7FFF_FFFF;
            end
            else
            begin
                qsat = q_reg[31:0];
            end
        end
    end

    // deformation gradient entry: floor shift, saturate to 32 bits
    logic signed [WW-1:0] fsh;
    logic signed [WW-1:0] f_max;
    logic signed [WW-1:0] f_min;
    logic signed [31:0]   fsat;

    assign fsh   = $signed(acc_reg) >>> FSH;
    assign f_max = $signed({{(WW-31){1'b0}}, {31{1'b1}}});
    assign f_min = $signed({{(WW-31){1'b1}}, {31{1'b0}}});

    always_comb
    begin
        if (fsh > f_max)
        begin
            fsat = 32'sh7FFF_FFFF;
        end
        else if (fsh < f_min)
        begin
            fsat = 32'sh8000_0000;
        end
        else
        begin
            fsat = fsh[31:0];
        end
    end

    // determinant output: floor shift, saturate to 64 bits
    logic signed [XW-1:0] dsh;
    logic signed [XW-1:0] d_max;
    logic signed [XW-1:0] d_min;
    logic signed [63:0]   dsat;

    assign dsh   = XW'(det_reg) >>> DSH;
    assign d_max = $signed({{(XW-63){1'b0}}, {63{1'b1}}});
    assign d_min = $signed({{(XW-63){1'b1}}, {63{1'b0}}});

    always_comb
    begin
        if (dsh > d_max)
        begin
            dsat = 64'sh7FFF_FFFF_FFFF_FFFF;
        end
        else if (dsh < d_min)
        begin
            dsat = 64'sh8000_0000_0000_0000;
        end
        else
        begin
            dsat = dsh[63:0];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ref_valid_reg <= 1'b0;
        end
        else if (cmd.ref_fail)
        begin
            ref_valid_reg <= 1'b0;
        end
        else if (cmd.set_valid)
        begin
            ref_valid_reg <= 1'b1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.ref_fail)
        begin
            for (int i = 0; i < 9; i++)
            begin
                inv_reg[i] <= '0;
            end
        end
        else if (cmd.inv_wr)
        begin
            inv_reg[cmd.idx] <= qsat;
        end
    end

    // result rows; the row on the output always sits at entries 0..2
    always_ff @(posedge clk)
    begin
        if (cmd.start)
        begin
            for (int i = 0; i < 9; i++)
            begin
                res_reg[i] <= '0;
            end
            kind_reg    <= command;
            det_out_reg <= '0;
        end
        else
        begin
            if (cmd.inv_wr)
            begin
                res_reg[cmd.idx] <= qsat;
            end
            else if (cmd.fres_wr)
            begin
                res_reg[cmd.idx] <= fsat;
            end
            else if (cmd.shift_rows)
            begin
                for (int i = 0; i < 6; i++)
                begin
                    res_reg[i] <= res_reg[i+3];
                end
            end
            if (cmd.det_out_wr)
            begin
                det_out_reg <= dsat;
            end
        end
        if (cmd.ref_fail || cmd.miss)
        begin
            sing_reg <= 1'b1;
        end
        else if (cmd.start)
        begin
            sing_reg <= 1'b0;
        end
    end

    assign stat.mac_busy  = mbusy_reg;
    assign stat.div_busy  = dbusy_reg;
    assign stat.det_zero  = (det_reg == '0);
    assign stat.ref_valid = ref_valid_reg;

    assign result_kind = kind_reg;
    assign col0_value  = res_reg[0];
    assign col1_value  = res_reg[1];
    assign col2_value  = res_reg[2];
    assign determinant = det_out_reg;
    assign singular    = sing_reg;

endmodule

>>> design/hexjac_ctrl.sv
// ----------------------------------------------------------------------------
// hexjac_ctrl
// Controller: sequences cofactors, determinant, divisions or the gradient
// products on the datapath, then hands out the three result rows.
// ----------------------------------------------------------------------------
module hexjac_ctrl (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 in_valid,
    input  logic                 command,
    input  logic [2:0]           node_index,
    input  logic                 out_ready,
    input  hexjac_pkg::dp_stat_t stat,
    output logic                 in_ready,
    output logic                 out_valid,
    output logic [1:0]           row_index,
    output logic                 last_row,
    output hexjac_pkg::dp_cmd_t  cmd
);
    import hexjac_pkg::*;

    ctrl_state_t state_reg, state_next;
    phase_t      phase_reg, phase_next;
    logic [3:0]  idx_reg, idx_next;
    logic [1:0]  term_reg, term_next;
    logic [1:0]  row_reg, row_next;

    logic [3:0]  term3;
    logic [1:0]  term_last;

    assign term3     = 4'({2'b00, term_reg} * 4'd3);
    assign term_last = (phase_reg == PH_COF) ? TERM_COF_LAST : TERM_MAT_LAST;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            phase_reg <= PH_COF;
            idx_reg   <= '0;
            term_reg  <= '0;
            row_reg   <= '0;
        end
        else
        begin
            state_reg <= state_next;
            phase_reg <= phase_next;
            idx_reg   <= idx_next;
            term_reg  <= term_next;
            row_reg   <= row_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        phase_next = phase_reg;
        idx_next   = idx_reg;
        term_next  = term_reg;
        row_next   = row_reg;
        cmd        = '0;
        in_ready   = 1'b0;
        out_valid  = 1'b0;

        unique case (state_reg)
            ST_IDLE:
            begin
                in_ready = 1'b1;
                if (in_valid && node_index == NODE_LAST)
                begin
                    cmd.start = 1'b1;
                    idx_next  = '0;
                    term_next = '0;
                    row_next  = '0;
                    if (command == CMD_REF)
                    begin
                        phase_next = PH_COF;
                        state_next = ST_MAC_A;
                    end
                    else if (!stat.ref_valid)
                    begin
                        cmd.miss     = 1'b1;
                        cmd.sums_clr = 1'b1;
                        state_next   = ST_EMIT;
                    end
                    else
                    begin
                        phase_next = PH_FMUL;
                        state_next = ST_MAC_A;
                    end
                end
            end

            ST_MAC_A:
            begin
                cmd.ld_a    = 1'b1;
                cmd.clr_acc = (term_reg == 2'd0);
                unique case (phase_reg)
                    PH_COF:
                    begin
                        cmd.idx = cof_src_a(idx_reg, term_reg[0]);
                    end
                    PH_DET:
                    begin
                        cmd.a_cof = 1'b1;
                        cmd.idx   = term3;
                    end
                    PH_FMUL:
                    begin
                        cmd.idx = term3 + {2'b00, row_of(idx_reg)};
                    end
                    default:
                    begin
                        cmd.idx = '0;
                    end
                endcase
                state_next = ST_MAC_B;
            end

            ST_MAC_B:
            begin
                cmd.ld_b = 1'b1;
                unique case (phase_reg)
                    PH_COF:
                    begin
                        cmd.idx = cof_src_b(idx_reg, term_reg[0]);
                        cmd.sub = term_reg[0];
                    end
                    PH_DET:
                    begin
                        cmd.idx = {2'b00, term_reg};
                    end
                    PH_FMUL:
                    begin
                        cmd.b_inv = 1'b1;
                        cmd.idx   = term3 + {2'b00, col_of(idx_reg)};
                    end
                    default:
                    begin
                        cmd.idx = '0;
                    end
                endcase
                state_next = ST_MAC_W;
            end

            ST_MAC_W:
            begin
                if (!stat.mac_busy)
                begin
                    if (term_reg != term_last)
                    begin
                        term_next  = term_reg + 2'd1;
                        state_next = ST_MAC_A;
                    end
                    else
                    begin
                        term_next = '0;
                        cmd.idx   = idx_reg;
                        unique case (phase_reg)
                            PH_COF:
                            begin
                                cmd.cof_wr = 1'b1;
                                state_next = ST_MAC_A;
                                if (idx_reg == IDX_LAST)
                                begin
                                    phase_next = PH_DET;
                                    idx_next   = '0;
                                end
                                else
                                begin
                                    idx_next = idx_reg + 4'd1;
                                end
                            end
                            PH_DET:
                            begin
                                cmd.det_wr = 1'b1;
                                state_next = ST_CHECK;
                            end
                            PH_FMUL:
                            begin
                                cmd.fres_wr = 1'b1;
                                if (idx_reg == IDX_LAST)
                                begin
                                    cmd.sums_clr = 1'b1;
                                    state_next   = ST_EMIT;
                                end
                                else
                                begin
                                    idx_next   = idx_reg + 4'd1;
                                    state_next = ST_MAC_A;
                                end
                            end
                            default:
                            begin
                                state_next = ST_IDLE;
                            end
                        endcase
                    end
                end
            end

            ST_CHECK:
            begin
                if (stat.det_zero)
                begin
                    cmd.ref_fail = 1'b1;
                    cmd.sums_clr = 1'b1;
                    state_next   = ST_EMIT;
                end
                else
                begin
                    cmd.det_out_wr = 1'b1;
                    idx_next       = '0;
                    state_next     = ST_DIV_GO;
                end
            end

            ST_DIV_GO:
            begin
                cmd.div_start = 1'b1;
                cmd.idx       = idx_reg;
                state_next    = ST_DIV_W;
            end

            ST_DIV_W:
            begin
                if (!stat.div_busy)
                begin
                    cmd.inv_wr = 1'b1;
                    cmd.idx    = idx_reg;
                    if (idx_reg == IDX_LAST)
                    begin
                        cmd.set_valid = 1'b1;
                        cmd.sums_clr  = 1'b1;
                        state_next    = ST_EMIT;
                    end
                    else
                    begin
                        idx_next   = idx_reg + 4'd1;
                        state_next = ST_DIV_GO;
                    end
                end
            end

            ST_EMIT:
            begin
                out_valid = 1'b1;
                // accumulation of the next element may go on, its last node waits
                in_ready  = (node_index != NODE_LAST);
                if (out_ready)
                begin
                    cmd.shift_rows = 1'b1;
                    if (row_reg == ROW_LAST)
                    begin
                        row_next   = '0;
                        state_next = ST_IDLE;
                    end
                    else
                    begin
                        row_next = row_reg + 2'd1;
                    end
                end
            end

            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    assign row_index = row_reg;
    assign last_row  = (row_reg == ROW_LAST);

endmodule

>>> design/hex8_jacobian_inverse_and_def_gradient.sv
// ----------------------------------------------------------------------------
// hex8_jacobian_inverse_and_def_gradient
// One-point Jacobian of an eight-node hexahedron; stores its inverse on a
// reference pass and gives the deformation gradient on a current pass.
// ----------------------------------------------------------------------------
//  channel | handshake          | payload
//  --------+--------------------+---------------------------------------------
//  input   | in_valid/in_ready  | command, node_index, coord_x/y/z
//  output  | out_valid/out_ready| result_kind, row_index, col0..2_value,
//          |                    | determinant, singular, last_row
//
// nodes 0 to 6 are taken one a cycle and only accumulate.
// node 7 runs one bit-serial multiplier of M = max(COORD_WIDTH+4, 32) bits:
// a reference pass needs 21 products and nine divisions with a numerator of
// 2*COORD_WIDTH+2*FRAC_BITS+12 bits; a current pass 27 products.
// results then leave one row a cycle while out_ready is high; nodes 0 to 6
// of the next element are taken meanwhile, node 7 waits until the third row
// is taken. reset clears the sums and the stored-reference flag at once.
// ----------------------------------------------------------------------------
module hex8_jacobian_inverse_and_def_gradient #(
    parameter int COORD_WIDTH = hexjac_pkg::COORD_WIDTH_DEF,
    parameter int FRAC_BITS   = hexjac_pkg::FRAC_BITS_DEF
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          in_valid,
    output logic                          in_ready,
    input  logic                          command,
    input  logic [2:0]                    node_index,
    input  logic signed [COORD_WIDTH-1:0] coord_x,
    input  logic signed [COORD_WIDTH-1:0] coord_y,
    input  logic signed [COORD_WIDTH-1:0] coord_z,
    output logic                          out_valid,
    input  logic                          out_ready,
    output logic                          result_kind,
    output logic [1:0]                    row_index,
    output logic signed [31:0]            col0_value,
    output logic signed [31:0]            col1_value,
    output logic signed [31:0]            col2_value,
    output logic signed [63:0]            determinant,
    output logic                          singular,
    output logic                          last_row
);
    import hexjac_pkg::*;

    dp_cmd_t  cmd;
    dp_stat_t stat;
    logic     in_fire;

    assign in_fire = in_valid && in_ready;

    hexjac_ctrl u_ctrl (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (in_valid),
        .command    (command),
        .node_index (node_index),
        .out_ready  (out_ready),
        .stat       (stat),
        .in_ready   (in_ready),
        .out_valid  (out_valid),
        .row_index  (row_index),
        .last_row   (last_row),
        .cmd        (cmd)
    );

    hexjac_dp #(
        .COORD_WIDTH (COORD_WIDTH),
        .FRAC_BITS   (FRAC_BITS)
    ) u_dp (
        .clk         (clk),
        .rst_n       (rst_n),
        .in_fire     (in_fire),
        .command     (command),
        .node_index  (node_index),
        .coord_x     (coord_x),
        .coord_y     (coord_y),
        .coord_z     (coord_z),
        .cmd         (cmd),
        .stat        (stat),
        .result_kind (result_kind),
        .col0_value  (col0_value),
        .col1_value  (col1_value),
        .col2_value  (col2_value),
        .determinant (determinant),
        .singular    (singular)
    );

`ifndef ASSERT_OFF
    // third row closes the run
    a_last_row_ends: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_ready && last_row |=> !out_valid)
        else $error("results continued after the last row");

    // a request that ends an element is never taken while rows are pending
    a_no_end_while_out: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && in_ready && node_index == NODE_LAST |-> !out_valid)
        else $error("final node taken while results pending");

    // rows step by one within a run
    a_row_steps: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_ready && !last_row |=>
            out_valid && row_index == $past(row_index) + 2'd1)
        else $error("row sequence broken");

    // a singular run carries no determinant
    a_sing_det: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && singular |-> determinant == 64'sd0)
        else $error("singular result with nonzero determinant");
`endif

endmodule

>>> tb/sv/testbench.sv
// ----------------------------------------------------------------------------
// testbench
// Self-checking bench for the hex8 Jacobian inverse and deformation gradient
// block: element passes go in one node per request, and every row that comes
// out is compared with an in-bench prediction done in wide integer arithmetic.
// ----------------------------------------------------------------------------
module testbench;
    import hexjac_pkg::*;

    localparam int  RUN_LIMIT   = 6000000;
    localparam int  NODE_TARGET = 430;
    localparam int  HOLD_CYCLES = 4000;

    typedef logic signed [255:0] wide_t;

    typedef struct packed {
        logic               kind;
        logic [1:0]         row;
        logic signed [31:0] c0;
        logic signed [31:0] c1;
        logic signed [31:0] c2;
        logic signed [63:0] det;
        logic               sing;
        logic               last;
    } row_res_t;

    typedef struct {
        logic               cmd;
        logic [2:0]         node;
        logic signed [31:0] x;
        logic signed [31:0] y;
        logic signed [31:0] z;
        bit                 typed;
        bit                 tsing;
    } node_req_t;

    logic               clk;
    logic               rst_n;
    logic               in_valid;
    logic               in_ready;
    logic               command;
    logic [2:0]         node_index;
    logic signed [31:0] coord_x;
    logic signed [31:0] coord_y;
    logic signed [31:0] coord_z;
    logic               out_valid;
    logic               out_ready;
    logic               result_kind;
    logic [1:0]         row_index;
    logic signed [31:0] col0_value;
    logic signed [31:0] col1_value;
    logic signed [31:0] col2_value;
    logic signed [63:0] determinant;
    logic               singular;
    logic               last_row;

    // predictor state
    logic signed [35:0] jac_sum[9];
    logic signed [31:0] ref_inv[9];
    logic               ref_ok;

    row_res_t  rows_due[$];
    bit        typed_on;
    bit        typed_sing;
    int        nodes_sent;
    int        passes_done;
    int        rows_checked;
    int        singular_rows;
    int        mismatches;
    int        idle_pct;
    int        stall_pct;
    bit        hold_off;
    int        cycles;
    node_req_t dir_tab[22];

    hex8_jacobian_inverse_and_def_gradient i_dut (
        .clk         (clk),
        .rst_n       (rst_n),
        .in_valid    (in_valid),
        .in_ready    (in_ready),
        .command     (command),
        .node_index  (node_index),
        .coord_x     (coord_x),
        .coord_y     (coord_y),
        .coord_z     (coord_z),
        .out_valid   (out_valid),
        .out_ready   (out_ready),
        .result_kind (result_kind),
        .row_index   (row_index),
        .col0_value  (col0_value),
        .col1_value  (col1_value),
        .col2_value  (col2_value),
        .determinant (determinant),
        .singular    (singular),
        .last_row    (last_row)
    );

    initial
    begin
        clk = 1'b0;
        forever #6 clk = ~clk;
    end

    function automatic wide_t widen(input logic signed [35:0] v);
        wide_t r;
        r = 256'(v);
        return r;
    endfunction

    function automatic logic [63:0] clamp(input wide_t a, input int bits);
        wide_t hi;
        wide_t lo;
        hi = (wide_t'(1) <<< (bits - 1)) - 1;
        lo = -(wide_t'(1) <<< (bits - 1));
        if (a > hi)
            return hi[63:0];
        if (a < lo)
            return lo[63:0];
        return a[63:0];
    endfunction

    // accumulate one node; on the last node work out the three rows
    task automatic predict_node(input logic cmd, input logic [2:0] node,
                                input logic signed [31:0] x, input logic signed [31:0] y,
                                input logic signed [31:0] z);
        logic               up[3];
        logic signed [31:0] xyz[3];
        logic [31:0]        col[9];
        logic [63:0]        det_o;
        logic               sing;
        wide_t              cof[9];
        wide_t              d;
        wide_t              acc;
        row_res_t           rr;
        up[0] = 1'(((node + 3'd1) >> 1) & 3'd1);
        up[1] = node[1];
        up[2] = node[2];
        xyz[0] = x;
        xyz[1] = y;
        xyz[2] = z;
        det_o = '0;
        sing = 1'b0;
        if (node == NODE_FIRST)
            foreach (jac_sum[i])
                jac_sum[i] = '0;
        for (int k = 0; k < 3; k++)
            for (int c = 0; c < 3; c++)
                jac_sum[k*3+c] = up[k] ? jac_sum[k*3+c] + 36'(xyz[c])
                                       : jac_sum[k*3+c] - 36'(xyz[c]);
        if (node != NODE_LAST)
            return;
        foreach (col[i])
            col[i] = '0;
        if (cmd == CMD_REF)
        begin
            for (int k = 0; k < 9; k++)
                cof[k] = widen(jac_sum[cof_src_a(4'(k), 1'b0)])
                         * widen(jac_sum[cof_src_b(4'(k), 1'b0)])
                       - widen(jac_sum[cof_src_a(4'(k), 1'b1)])
                         * widen(jac_sum[cof_src_b(4'(k), 1'b1)]);
            d = widen(jac_sum[0]) * cof[0] + widen(jac_sum[1]) * cof[3]
              + widen(jac_sum[2]) * cof[6];
            if (d == 0)
            begin
                sing = 1'b1;
                ref_ok = 1'b0;
                foreach (ref_inv[i])
                    ref_inv[i] = '0;
            end
            else
            begin
                det_o = clamp(d >>> 41, 64);
                for (int k = 0; k < 9; k++)
                begin
                    col[k] = 32'(clamp((cof[k] <<< 35) / d, 32));
                    ref_inv[k] = col[k];
                end
                ref_ok = 1'b1;
            end
        end
        else if (!ref_ok)
            sing = 1'b1;
        else
        begin
            for (int r = 0; r < 3; r++)
                for (int c = 0; c < 3; c++)
                begin
                    acc = 0;
                    for (int k = 0; k < 3; k++)
                        acc = acc + widen(jac_sum[k*3+r]) * widen(36'(ref_inv[k*3+c]));
                    col[r*3+c] = 32'(clamp(acc >>> 19, 32));
                end
        end
        foreach (jac_sum[i])
            jac_sum[i] = '0;
        for (int r = 0; r < 3; r++)
        begin
            rr.kind = cmd;
            rr.row  = 2'(r);
            rr.c0   = col[r*3];
            rr.c1   = col[r*3+1];
            rr.c2   = col[r*3+2];
            rr.det  = det_o;
            rr.sing = sing;
            rr.last = (2'(r) == ROW_LAST);
            // rows read straight off the spec for the hand-written cases
            if (typed_on)
            begin
                rr.c0 = '0;
                rr.c1 = '0;
                rr.c2 = '0;
                rr.det = '0;
                rr.sing = typed_sing;
            end
            rows_due.push_back(rr);
        end
        passes_done++;
    endtask

    always @(posedge clk)
    begin
        row_res_t got;
        row_res_t want;
        if (rst_n && in_valid && in_ready)
            predict_node(command, node_index, coord_x, coord_y, coord_z);
        if (rst_n && out_valid && out_ready)
        begin
            got = '{result_kind, row_index, col0_value, col1_value, col2_value,
                    determinant, singular, last_row};
            if (rows_due.size() == 0)
            begin
                mismatches++;
                if (mismatches <= 10)
                    $display("unexpected row: %p", got);
            end
            else
            begin
                want = rows_due.pop_front();
                rows_checked++;
                if (got.sing)
                    singular_rows++;
                if (got !== want)
                begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("row mismatch\n  exp %p\n  got %p", want, got);
                end
            end
        end
    end

    always @(posedge clk)
    begin
        cycles++;
        if (cycles > RUN_LIMIT)
        begin
            $display("timeout after %0d cycles", cycles);
            $display("CHECK FAILED");
            $finish;
        end
    end

    // receiver side
    always @(negedge clk)
        out_ready <= !hold_off && ($urandom_range(99) >= stall_pct);

    // long hold on the output so the block backs up into its input
    initial
    begin
        wait (nodes_sent >= 200);
        @(negedge clk);
        hold_off = 1'b1;
        repeat (HOLD_CYCLES) @(negedge clk);
        hold_off = 1'b0;
    end

    task automatic send_node(input node_req_t q);
        while ($urandom_range(99) < idle_pct)
        begin
            in_valid = 1'b0;
            @(negedge clk);
        end
        typed_on   = q.typed;
        typed_sing = q.tsing;
        command    = q.cmd;
        node_index = q.node;
        coord_x    = q.x;
        coord_y    = q.y;
        coord_z    = q.z;
        in_valid   = 1'b1;
        do
            @(posedge clk);
        while (!in_ready);
        @(negedge clk);
        in_valid = 1'b0;
        typed_on = 1'b0;
        nodes_sent++;
    endtask

    task automatic set_phase(input int n);
        case (n % 4)
            0: begin idle_pct = 0;  stall_pct = 0;  end
            1: begin idle_pct = 68; stall_pct = 0;  end
            2: begin idle_pct = 0;  stall_pct = 68; end
            default: begin idle_pct = 7; stall_pct = 7; end
        endcase
    endtask

    initial
    begin
        node_req_t q;
        logic [31:0] scale;
        int elem;
        rst_n = 1'b0;
        in_valid = 1'b0;
        out_ready = 1'b0;
        command = CMD_REF;
        node_index = NODE_FIRST;
        coord_x = '0;
        coord_y = '0;
        coord_z = '0;
        hold_off = 1'b0;
        typed_on = 1'b0;
        typed_sing = 1'b0;
        idle_pct = 0;
        stall_pct = 0;
        foreach (jac_sum[i])
            jac_sum[i] = '0;
        foreach (ref_inv[i])
            ref_inv[i] = '0;
        ref_ok = 1'b0;
        repeat (9) @(negedge clk);
        rst_n = 1'b1;

        // current pass with nothing stored, then an all-zero reference
        for (int i = 0; i < 16; i++)
            dir_tab[i] = '{(i < 8) ? CMD_CUR : CMD_REF, 3'(i % 8), 0, 0, 0, 1, 1};
        // short passes at the coordinate extremes, node 0 restarting the sums
        dir_tab[16] = '{CMD_REF, 3'd0, 32'h7fffffff, 32'h80000000, 32'h7fffffff, 0, 0};
        dir_tab[17] = '{CMD_REF, 3'd7, 32'h80000000, 32'h7fffffff, 32'h12345678, 0, 0};
        dir_tab[18] = '{CMD_CUR, 3'd7, 32'h7fffffff, 32'h7fffffff, 32'h80000000, 0, 0};
        dir_tab[19] = '{CMD_REF, 3'd3, 32'h80000000, 32'h80000000, 32'h80000000, 0, 0};
        dir_tab[20] = '{CMD_REF, 3'd5, 32'h7fffffff, 32'h00010000, 32'hffff0000, 0, 0};
        dir_tab[21] = '{CMD_REF, 3'd7, 32'h00020000, 32'hfffe0000, 32'h7fffffff, 0, 0};
        foreach (dir_tab[i])
            send_node(dir_tab[i]);

        elem = 0;
        while (nodes_sent < NODE_TARGET)
        begin
            set_phase(elem / 4);
            elem++;
            if ($urandom_range(9) == 0)
            begin
                // broken sequence: arbitrary nodes and values
                repeat ($urandom_range(1, 10))
                begin
                    q = '{1'($urandom_range(1)), 3'($urandom_range(7)), $urandom, $urandom,
                          $urandom, 0, 0};
                    send_node(q);
                end
            end
            else
            begin
                q.cmd = ($urandom_range(2) == 0) ? CMD_REF : CMD_CUR;
                scale = 32'd1 << $urandom_range(8, 24);
                for (int n = 0; n < 8; n++)
                begin
                    q.node = 3'(n);
                    q.typed = 0;
                    q.tsing = 0;
                    if ($urandom_range(7) == 0)
                    begin
                        q.x = $urandom;
                        q.y = $urandom;
                        q.z = $urandom;
                    end
                    else
                    begin
                        // corner of a distorted box, signs follow the node numbering
                        q.x = ((((n + 1) >> 1) & 1) ? scale : -scale) + $signed($urandom_range(4095)) - 2048;
                        q.y = (((n >> 1) & 1) ? scale : -scale) + $signed($urandom_range(4095)) - 2048;
                        q.z = (((n >> 2) & 1) ? scale : -scale) + $signed($urandom_range(4095)) - 2048;
                    end
                    send_node(q);
                end
            end
        end

        in_valid = 1'b0;
        wait (rows_due.size() == 0);
        repeat (200) @(negedge clk);
        $display("sent %0d nodes, %0d passes ended, %0d rows checked (%0d singular)",
                 nodes_sent, passes_done, rows_checked, singular_rows);
        $display("idle and stall mixes cycled, one output hold of %0d cycles", HOLD_CYCLES);
        if (mismatches == 0 && rows_due.size() == 0)
            $display("CHECK OK");
        else
            $display("CHECK FAILED");
        $finish;
    end

endmodule
